// ----- sv/srs_pkg.sv -----
// Package for the stepper ramp sequencer: field widths, register indexes,
// reset values, shared structs and the ramp delay table.
// No dependencies.
package srs_pkg;

	// Field widths.
	localparam int unsigned PATTERN_W = 8;
	localparam int unsigned DELAY_W   = 12;
	localparam int unsigned LEAD_W    = 8;
	localparam int unsigned COUNT_W   = 10;
	localparam int unsigned INDEX_W   = 11;
	localparam int unsigned PHASE_W   = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 12;
	// Width of the step arithmetic: holds 2*RAMP_LEN plus the largest step count.
	localparam int unsigned CALC_W    = 12;

	// Ramp length default and table depth.
	localparam int unsigned RAMP_LEN_DEF = 13;
	localparam int unsigned ROM_DEPTH    = 13;

	// Operation codes of an input item.
	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_DLY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REL_LEAD  = 3'd5;

	// Register reset values.
	localparam logic [PATTERN_W-1:0] PATTERN_A_RST = 8'd54;
	localparam logic [PATTERN_W-1:0] PATTERN_B_RST = 8'd46;
	localparam logic [PATTERN_W-1:0] PATTERN_C_RST = 8'd45;
	localparam logic [PATTERN_W-1:0] PATTERN_D_RST = 8'd53;
	localparam logic [DELAY_W-1:0]   FIXED_DLY_RST = 12'd2000;
	localparam logic [LEAD_W-1:0]    REL_LEAD_RST  = 8'd15;

	// Configuration register contents.
	typedef struct packed {
		logic [PATTERN_W-1:0] pattern_a;
		logic [PATTERN_W-1:0] pattern_b;
		logic [PATTERN_W-1:0] pattern_c;
		logic [PATTERN_W-1:0] pattern_d;
		logic [DELAY_W-1:0]   fixed_delay;
		logic [LEAD_W-1:0]    release_lead;
	} srs_cfg_t;

	// One result item.
	typedef struct packed {
		logic [PATTERN_W-1:0] coil_pattern;
		logic [DELAY_W-1:0]   step_delay;
		logic                 conveyor_release;
		logic                 move_done;
	} srs_result_t;

	// Ramp delay table; indexes past the end read the last entry.
	function automatic logic [DELAY_W-1:0] ramp_delay(input logic [CALC_W-1:0] idx);
		logic [DELAY_W-1:0] d;
		case (idx)
			12'd0:   d = 12'd1800;
			12'd1:   d = 12'd1780;
			12'd2:   d = 12'd1720;
			12'd3:   d = 12'd1620;
			12'd4:   d = 12'd1500;
			12'd5:   d = 12'd1360;
			12'd6:   d = 12'd1200;
			12'd7:   d = 12'd1040;
			12'd8:   d = 12'd900;
			12'd9:   d = 12'd780;
			12'd10:  d = 12'd680;
			12'd11:  d = 12'd620;
			default: d = 12'd600;
		endcase
		return d;
	endfunction

endpackage

// ----- sv/srs_if.sv -----
// Stream interfaces of the stepper ramp sequencer: command channel and
// step result channel, each with valid/ready handshake. No dependencies.
interface srs_cmd_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [9:0] step_count;
	logic       direction;
	logic       ramped;

	modport source (output valid, op, step_count, direction, ramped, input ready);
	modport sink (input valid, op, step_count, direction, ramped, output ready);
endinterface

interface srs_step_if;
	logic        valid;
	logic        ready;
	logic [7:0]  coil_pattern;
	logic [11:0] step_delay;
	logic        conveyor_release;
	logic        move_done;

	modport source (output valid, coil_pattern, step_delay, conveyor_release, move_done,
		input ready);
	modport sink (input valid, coil_pattern, step_delay, conveyor_release, move_done,
		output ready);
endinterface

// ----- sv/srs_cfg_regs.sv -----
// Configuration register file of the stepper ramp sequencer.
// Depends on srs_pkg.
module srs_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [srs_pkg::CFG_IDX_W-1:0]    index,
	input  logic [srs_pkg::CFG_DAT_W-1:0]    data,
	output srs_pkg::srs_cfg_t                cfg
);
	import srs_pkg::*;

	srs_cfg_t cfg_q;

	// Register writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_a    <= PATTERN_A_RST;
			cfg_q.pattern_b    <= PATTERN_B_RST;
			cfg_q.pattern_c    <= PATTERN_C_RST;
			cfg_q.pattern_d    <= PATTERN_D_RST;
			cfg_q.fixed_delay  <= FIXED_DLY_RST;
			cfg_q.release_lead <= REL_LEAD_RST;
		end else if (we) begin
			case (index)
				REG_PATTERN_A: cfg_q.pattern_a    <= data[PATTERN_W-1:0];
				REG_PATTERN_B: cfg_q.pattern_b    <= data[PATTERN_W-1:0];
				REG_PATTERN_C: cfg_q.pattern_c    <= data[PATTERN_W-1:0];
				REG_PATTERN_D: cfg_q.pattern_d    <= data[PATTERN_W-1:0];
				REG_FIXED_DLY: cfg_q.fixed_delay  <= data[DELAY_W-1:0];
				REG_REL_LEAD:  cfg_q.release_lead <= data[LEAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/srs_step_core.sv -----
// Move state and single-pass step computation of the stepper ramp sequencer.
// Depends on srs_pkg.
module srs_step_core #(
	parameter int unsigned RAMP_LEN = srs_pkg::RAMP_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srs_pkg::srs_cfg_t                 cfg,
	input  logic                              take,
	input  logic                              op,
	input  logic [srs_pkg::COUNT_W-1:0]       step_count,
	input  logic                              direction,
	input  logic                              ramped,
	output logic                              res_valid,
	output srs_pkg::srs_result_t              res
);
	import srs_pkg::*;

	localparam logic [CALC_W-1:0] RAMP     = CALC_W'(RAMP_LEN);
	localparam logic [CALC_W-1:0] TWO_RAMP = CALC_W'(2 * RAMP_LEN);

	logic [PHASE_W-1:0] phase_q;
	logic               busy_q;
	logic               dir_q;
	logic               ramped_q;
	logic [COUNT_W-1:0] target_q;
	logic [INDEX_W-1:0] index_q;

	logic [PHASE_W-1:0] phase_nxt;
	logic [CALC_W-1:0]  steps;
	logic [CALC_W-1:0]  k;
	logic [CALC_W-1:0]  cruise;
	logic [CALC_W-1:0]  total;
	logic [CALC_W-1:0]  rel_step;
	logic [DELAY_W-1:0] dly;
	logic               rel;
	logic               done;
	logic               is_start;
	logic               is_step;

	assign is_start = take && (op == OP_START) && !busy_q;
	assign is_step  = take && (op == OP_ADVANCE) && busy_q;

	// Next phase, wrapping over 1..4.
	always_comb begin
		if (!dir_q) begin
			phase_nxt = (phase_q >= 3'd4) ? 3'd1 : phase_q + 3'd1;
		end else begin
			phase_nxt = (phase_q <= 3'd1) ? 3'd4 : phase_q - 3'd1;
		end
	end

	// Step delay, release and end-of-move flag.
	always_comb begin
		steps    = CALC_W'(target_q);
		k        = CALC_W'(index_q);
		cruise   = (steps >= TWO_RAMP) ? steps - TWO_RAMP : '0;
		rel_step = steps - RAMP - CALC_W'(cfg.release_lead);
		rel      = 1'b0;
		if (ramped_q) begin
			total = TWO_RAMP + cruise;
			if (k < RAMP) begin
				dly = ramp_delay(k);
			end else if (k < RAMP + cruise) begin
				dly = ramp_delay(RAMP - 12'd1);
				// Release index is valid only when it lies past the ramp-up.
				rel = (steps >= TWO_RAMP + CALC_W'(cfg.release_lead)) && (k == rel_step);
			end else begin
				dly = ramp_delay(total - 12'd1 - k);
			end
		end else begin
			total = steps;
			dly   = cfg.fixed_delay;
		end
		done = (k + 12'd1 >= total);
		if (!ramped_q && done) begin
			rel = 1'b1;
		end
	end

	// Result for this step.
	always_comb begin
		case (phase_nxt)
			3'd1:    res.coil_pattern = cfg.pattern_a;
			3'd2:    res.coil_pattern = cfg.pattern_b;
			3'd3:    res.coil_pattern = cfg.pattern_c;
			default: res.coil_pattern = cfg.pattern_d;
		endcase
		res.step_delay       = dly;
		res.conveyor_release = rel;
		res.move_done        = done;
	end

	assign res_valid = is_step;

	// Move state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			busy_q   <= 1'b0;
			dir_q    <= 1'b0;
			ramped_q <= 1'b0;
			target_q <= '0;
			index_q  <= '0;
		end else if (is_start) begin
			target_q <= step_count;
			dir_q    <= direction;
			ramped_q <= ramped;
			index_q  <= '0;
			busy_q   <= ramped || (step_count != '0);
		end else if (is_step) begin
			phase_q <= phase_nxt;
			if (done) begin
				busy_q  <= 1'b0;
				index_q <= '0;
			end else begin
				index_q <= index_q + 11'd1;
			end
		end
	end

endmodule

// ----- sv/srs_out_buf.sv -----
// Two-entry output buffer (output register plus skid register) for the
// step result channel. Depends on srs_pkg.
module srs_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  srs_pkg::srs_result_t push_data,
	output logic                 space,
	output logic                 out_valid,
	input  logic                 out_ready,
	output srs_pkg::srs_result_t out_data
);
	import srs_pkg::*;

	logic        main_valid_q;
	logic        skid_valid_q;
	srs_result_t main_q;
	srs_result_t skid_q;
	logic        pop;

	assign pop   = main_valid_q && out_ready;
	assign space = !skid_valid_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			main_valid_q <= push || skid_valid_q;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			main_valid_q <= 1'b1;
			skid_valid_q <= main_valid_q;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule

// ----- sv/stepper_ramp_sequencer_core.sv -----
// Stepper ramp sequencer top level: one command in, at most one step result out.
// Step results are registered in the output buffer. Throughput: one command per
// cycle while the buffer has space; the two-entry output buffer keeps the
// command side open while a result waits. Reset (arst_n) clears the move state,
// phase and buffer, and loads the configuration registers with their defaults.
// Depends on srs_pkg, srs_if, srs_cfg_regs, srs_step_core and srs_out_buf.
module stepper_ramp_sequencer_core #(
	parameter int unsigned RAMP_LEN = srs_pkg::RAMP_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	srs_cmd_if.sink                       cmd,
	srs_step_if.source                    step,
	input  logic                          cfg_we,
	input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srs_pkg::CFG_DAT_W-1:0] cfg_data
);
	import srs_pkg::*;

	srs_cfg_t    cfg;
	srs_result_t res;
	srs_result_t out_data;
	logic        res_valid;
	logic        space;
	logic        take;

	assign cmd.ready = space;
	assign take      = cmd.valid && space;

	srs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	srs_step_core #(
		.RAMP_LEN (RAMP_LEN)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.take       (take),
		.op         (cmd.op),
		.step_count (cmd.step_count),
		.direction  (cmd.direction),
		.ramped     (cmd.ramped),
		.res_valid  (res_valid),
		.res        (res)
	);

	srs_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (step.valid),
		.out_ready (step.ready),
		.out_data  (out_data)
	);

	// Result transfer payload.
	assign step.coil_pattern     = out_data.coil_pattern;
	assign step.step_delay       = out_data.step_delay;
	assign step.conveyor_release = out_data.conveyor_release;
	assign step.move_done        = out_data.move_done;

endmodule

// ----- tb/sv/srs_tb_pkg.sv -----
`timescale 1ns / 1ps
// Step predictor and result checker for the stepper ramp sequencer testbench.
// Depends on srs_pkg.
package srs_tb_pkg;
	import srs_pkg::*;

	// Ramp length the block is built with.
	localparam int RAMP_STEPS = 13;

	// Tracks the sequencer's move state, predicts each step result and checks
	// the results that come back in order.
	class step_ledger;
		logic [PATTERN_W-1:0] coil_by_phase [4];
		logic [DELAY_W-1:0]   const_delay;
		logic [LEAD_W-1:0]    lead;
		logic [DELAY_W-1:0]   ramp_table [13];
		logic [PHASE_W-1:0]   phase;
		bit                   moving;
		bit                   ccw;
		bit                   use_ramp;
		logic [COUNT_W-1:0]   target;
		int                   done_steps;
		srs_result_t          due_steps [$];
		int unsigned          errors;

		function new();
			coil_by_phase = '{PATTERN_A_RST, PATTERN_B_RST, PATTERN_C_RST, PATTERN_D_RST};
			const_delay = FIXED_DLY_RST;
			lead = REL_LEAD_RST;
			ramp_table = '{12'd1800, 12'd1780, 12'd1720, 12'd1620, 12'd1500, 12'd1360,
				12'd1200, 12'd1040, 12'd900, 12'd780, 12'd680, 12'd620, 12'd600};
			phase = '0;
			moving = 1'b0;
			ccw = 1'b0;
			use_ramp = 1'b0;
			target = '0;
			done_steps = 0;
			errors = 0;
		endfunction

		// Ramp delay lookup; positions past the table hold its last entry.
		function logic [DELAY_W-1:0] ramp_at(int k);
			if (k < 0)
				k = 0;
			if (k > $size(ramp_table) - 1)
				k = $size(ramp_table) - 1;
			return ramp_table[k];
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_PATTERN_A: coil_by_phase[0] = data[PATTERN_W-1:0];
				REG_PATTERN_B: coil_by_phase[1] = data[PATTERN_W-1:0];
				REG_PATTERN_C: coil_by_phase[2] = data[PATTERN_W-1:0];
				REG_PATTERN_D: coil_by_phase[3] = data[PATTERN_W-1:0];
				REG_FIXED_DLY: const_delay = data[DELAY_W-1:0];
				REG_REL_LEAD:  lead = data[LEAD_W-1:0];
				default: ;
			endcase
		endfunction

		// Called for every command transfer; queues the step result, if the command causes one.
		function void take_command(op_t op, logic [COUNT_W-1:0] count, logic dir,
			logic ramp);
			int steps;
			int cruise;
			int total;
			int k;
			int rel_at;
			srs_result_t r;

			if (op == OP_START) begin
				// A start during a move is dropped.
				if (moving)
					return;
				target = count;
				ccw = dir;
				use_ramp = ramp;
				done_steps = 0;
				moving = ramp || (count != 0);
				return;
			end
			if (!moving)
				return;

			// Full-step phase walk over 1..4.
			if (!ccw)
				phase = (phase >= 3'd4) ? 3'd1 : phase + 3'd1;
			else
				phase = (phase <= 3'd1) ? 3'd4 : phase - 3'd1;

			steps = int'(target);
			k = done_steps;
			r.conveyor_release = 1'b0;
			if (use_ramp) begin
				// Ramp up, cruise at the last table delay, then ramp down.
				cruise = steps - 2 * RAMP_STEPS;
				if (cruise < 0)
					cruise = 0;
				total = 2 * RAMP_STEPS + cruise;
				if (k < RAMP_STEPS) begin
					r.step_delay = ramp_at(k);
				end else if (k < RAMP_STEPS + cruise) begin
					r.step_delay = ramp_at(RAMP_STEPS - 1);
					rel_at = steps - 2 * RAMP_STEPS - int'(lead);
					r.conveyor_release = (rel_at >= 0) && (k - RAMP_STEPS == rel_at);
				end else begin
					r.step_delay = ramp_at(RAMP_STEPS - 1 - (k - RAMP_STEPS - cruise));
				end
			end else begin
				total = steps;
				r.step_delay = const_delay;
			end

			r.move_done = (k + 1 >= total);
			if (!use_ramp && r.move_done)
				r.conveyor_release = 1'b1;

			case (phase)
				3'd1: r.coil_pattern = coil_by_phase[0];
				3'd2: r.coil_pattern = coil_by_phase[1];
				3'd3: r.coil_pattern = coil_by_phase[2];
				default: r.coil_pattern = coil_by_phase[3];
			endcase

			if (r.move_done) begin
				moving = 1'b0;
				done_steps = 0;
			end else begin
				done_steps++;
			end
			due_steps.push_back(r);
		endfunction

		// Called for every step result transfer.
		function void check_step(srs_result_t got);
			srs_result_t want;

			if (due_steps.size() == 0) begin
				$error("step result with none expected: coil_pattern %0d step_delay %0d",
					got.coil_pattern, got.step_delay);
				errors++;
				return;
			end
			want = due_steps.pop_front();
			if (got.coil_pattern !== want.coil_pattern) begin
				$error("coil_pattern: expected %0d, got %0d", want.coil_pattern,
					got.coil_pattern);
				errors++;
			end
			if (got.step_delay !== want.step_delay) begin
				$error("step_delay: expected %0d, got %0d", want.step_delay, got.step_delay);
				errors++;
			end
			if (got.conveyor_release !== want.conveyor_release) begin
				$error("conveyor_release: expected %0d, got %0d", want.conveyor_release,
					got.conveyor_release);
				errors++;
			end
			if (got.move_done !== want.move_done) begin
				$error("move_done: expected %0d, got %0d", want.move_done, got.move_done);
				errors++;
			end
		endfunction
	endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the stepper ramp sequencer testbench: clock, reset, command and
// configuration drivers, result monitor. Depends on srs_pkg, srs_if, srs_tb_pkg and stepper_ramp_sequencer_core.
module tb_top;
	import srs_pkg::*;
	import srs_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	srs_cmd_if  cmd();
	srs_step_if step();

	step_ledger ledger;
	int         src_rate = 0;
	int         sink_rate = 0;
	int         sink_hold = 0;
	int         quiet_cycles = 0;
	int         moved_items = 0;

	stepper_ramp_sequencer_core #(
		.RAMP_LEN(RAMP_STEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.step(step),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side back-pressure: with a chance of sink_rate percent, ready drops and a hold counter keeps it low.
	always @(posedge clk) begin
		if (arst_n !== 1'b1) begin
			sink_hold <= 0;
			step.ready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			step.ready <= 1'b0;
		end else if (sink_rate != 0 && $urandom_range(0, 99) < sink_rate) begin
			sink_hold <= $urandom_range(0, 4);
			step.ready <= 1'b0;
		end else begin
			step.ready <= 1'b1;
		end
	end

	// Check every step result transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && step.valid === 1'b1 && step.ready === 1'b1)
			ledger.check_step({step.coil_pattern, step.step_delay, step.conveyor_release,
				step.move_done});
	end

	// Stop the run when no transfer happens on either channel for too long.
	always @(posedge clk) begin
		if ((cmd.valid === 1'b1 && cmd.ready === 1'b1) ||
			(step.valid === 1'b1 && step.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// One command transfer; with a chance of src_rate percent, valid drops for a random gap in front of it.
	task automatic send_command(op_t op, logic [COUNT_W-1:0] count, logic dir, logic ramp);
		int gap;

		if (src_rate != 0 && $urandom_range(0, 99) < src_rate) begin
			gap = $urandom_range(1, 5);
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.step_count <= count;
		cmd.direction <= dir;
		cmd.ramped <= ramp;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		ledger.take_command(op, count, dir, ramp);
	endtask

	// A whole move: the start and every advance it takes, with some dropped
	// commands mixed in (starts during the move, advances after it).
	task automatic run_move(logic [COUNT_W-1:0] count, logic dir, logic ramp);
		int len;

		if (ramp)
			len = (count > 2 * RAMP_STEPS) ? int'(count) : 2 * RAMP_STEPS;
		else
			len = int'(count);
		send_command(OP_START, count, dir, ramp);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_command(OP_START, COUNT_W'($urandom), 1'($urandom), 1'($urandom));
			send_command(OP_ADVANCE, COUNT_W'($urandom), 1'($urandom), 1'($urandom));
		end
		if ($urandom_range(0, 9) == 0)
			send_command(OP_ADVANCE, COUNT_W'($urandom), 1'($urandom), 1'($urandom));
		moved_items += len + 1;
	endtask

	// Mostly short moves of either mode; now and then a long one.
	task automatic random_move();
		logic                ramp;
		logic [COUNT_W-1:0] count;

		ramp = 1'($urandom);
		if ($urandom_range(0, 39) == 0)
			count = COUNT_W'($urandom_range(71, 200));
		else if (ramp)
			count = COUNT_W'($urandom_range(0, 70));
		else
			count = COUNT_W'($urandom_range(0, 30));
		run_move(count, 1'($urandom), ramp);
	endtask

	// Hold off commands until every predicted result has arrived.
	task automatic wait_drained();
		cmd.valid <= 1'b0;
		while (ledger.due_steps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all six registers, one per cycle; only called while idle.
	task automatic apply_settings(logic [7:0] pa, logic [7:0] pb, logic [7:0] pc,
		logic [7:0] pd, logic [11:0] delay, logic [7:0] lead_steps);
		logic [CFG_IDX_W-1:0] idx [6];
		logic [CFG_DAT_W-1:0] val [6];

		idx = '{REG_PATTERN_A, REG_PATTERN_B, REG_PATTERN_C, REG_PATTERN_D,
			REG_FIXED_DLY, REG_REL_LEAD};
		val = '{CFG_DAT_W'(pa), CFG_DAT_W'(pb), CFG_DAT_W'(pc), CFG_DAT_W'(pd),
			CFG_DAT_W'(delay), CFG_DAT_W'(lead_steps)};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			ledger.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// One settings phase of random moves.
	task automatic random_phase(int items, int src, int sink);
		int stop_at;

		wait_drained();
		apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			12'($urandom), 8'($urandom_range(0, 20)));
		src_rate = src;
		sink_rate = sink;
		stop_at = moved_items + items;
		while (moved_items < stop_at)
			random_move();
	endtask

	initial begin
		ledger = new();
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = OP_START;
		cmd.step_count = '0;
		cmd.direction = 1'b0;
		cmd.ramped = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset settings: ignored commands, a zero
		// constant move, the first step after reset going counterclockwise
		// to phase four, and a start during a move.
		src_rate = 20;
		sink_rate = 20;
		send_command(OP_ADVANCE, 10'd0, 1'b0, 1'b0);
		send_command(OP_START, 10'd0, 1'b0, 1'b0);
		send_command(OP_ADVANCE, 10'd1023, 1'b1, 1'b1);
		run_move(10'd2, 1'b1, 1'b0);
		send_command(OP_ADVANCE, 10'd0, 1'b0, 1'b0);
		send_command(OP_START, 10'd3, 1'b0, 1'b0);
		send_command(OP_ADVANCE, 10'd0, 1'b0, 1'b0);
		send_command(OP_START, 10'd1023, 1'b1, 1'b1);
		send_command(OP_ADVANCE, 10'd0, 1'b0, 1'b0);
		send_command(OP_ADVANCE, 10'd0, 1'b0, 1'b0);

		// All registers at zero; ramped moves of zero and of too few steps
		// still make the full ramp.
		wait_drained();
		apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 8'd0);
		src_rate = 30;
		sink_rate = 30;
		run_move(10'd0, 1'b0, 1'b1);
		run_move(10'd20, 1'b1, 1'b1);
		moved_items = 0;
		while (moved_items < 40)
			random_move();

		// All registers at their maximum, no idling; a ramped move just long
		// enough for the largest lead releases on its first cruise step.
		wait_drained();
		apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 12'd4095, 8'd255);
		src_rate = 0;
		sink_rate = 0;
		run_move(10'd281, 1'b0, 1'b1);
		moved_items = 0;
		while (moved_items < 30)
			random_move();

		// Random settings with varied idling; one long constant move.
		wait_drained();
		apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			12'($urandom), 8'($urandom_range(0, 20)));
		src_rate = 25;
		sink_rate = 10;
		run_move(10'd80, 1'b1, 1'b0);
		moved_items = 0;
		while (moved_items < 40)
			random_move();

		moved_items = 0;
		random_phase(40, 10, 40);
		random_phase(40, 40, 5);
		// Last stretch runs without idling on either side.
		random_phase(40, 0, 0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (ledger.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/srs_pkg.sv
sv/srs_if.sv
sv/srs_cfg_regs.sv
sv/srs_step_core.sv
sv/srs_out_buf.sv
sv/stepper_ramp_sequencer_core.sv
tb/sv/srs_tb_pkg.sv
tb/sv/tb_top.sv
